FILE: rtl/core/ivd_pkg.sv
package ivd_pkg;

  localparam int DATA_W = 64;
  localparam int CFG_IDX_W = 3;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Z       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMPACT_FORCE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMPACT_RADIUS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_YIELD_STRENGTH = 3'd5;

  localparam logic [62:0] RADIUS_RESET = 63'd21474836480;
  localparam logic signed [63:0] YIELD_RESET = 64'sd42949672960;

  localparam logic signed [63:0] K_FATIGUE_SCALE = 64'sd4294967;
  localparam logic signed [63:0] K_HALF          = 64'sd2147483648;
  localparam logic signed [63:0] K_TENTH         = 64'sd429496730;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  localparam int QMUL_LAT = 3;
  localparam int SQRT_STEPS = 48;
  localparam int DIV_STEPS = 32;
  localparam int SQRT_STEPS_PER_STAGE = 2;
  localparam int DIV_STEPS_PER_STAGE = 2;

  typedef struct packed {
    logic signed [63:0] pos_x;
    logic signed [63:0] pos_y;
    logic signed [63:0] pos_z;
    logic signed [63:0] vel_x;
    logic signed [63:0] vel_y;
    logic signed [63:0] vel_z;
    logic signed [63:0] fatigue;
  } vtx_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return $signed(s[63:0]);
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return $signed(s[63:0]);
  endfunction

endpackage

FILE: rtl/core/impact_vertex_deformation_top.sv
// channel   direction  handshake              payload
// cfg       in         cfg_write              cfg_index, cfg_data
// vertex    in         in_valid / in_ready    pos_*, vel_*, fatigue_in
// result    out        out_valid / out_ready  new_pos_*, new_vel_*, fatigue_out, flags
//
// one request per cycle sustained while the output is not stalled; at the
// default stage split the path runs through the 24-stage square root and
// 17-stage falloff divider plus four 3-stage multipliers in series
// rst is synchronous and clears all valid bits and loads the config defaults
// a stalled output freezes the whole pipeline in place, so in_ready follows
// !out_valid || out_ready and nothing is dropped or repeated
module impact_vertex_deformation_top #(
  parameter int SQRT_STEPS_PER_STAGE = ivd_pkg::SQRT_STEPS_PER_STAGE,
  parameter int DIV_STEPS_PER_STAGE  = ivd_pkg::DIV_STEPS_PER_STAGE
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [ivd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [63:0]             pos_x,
  input  logic signed [63:0]             pos_y,
  input  logic signed [63:0]             pos_z,
  input  logic signed [63:0]             vel_x,
  input  logic signed [63:0]             vel_y,
  input  logic signed [63:0]             vel_z,
  input  logic signed [63:0]             fatigue_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [63:0]             new_pos_x,
  output logic signed [63:0]             new_pos_y,
  output logic signed [63:0]             new_pos_z,
  output logic signed [63:0]             new_vel_x,
  output logic signed [63:0]             new_vel_y,
  output logic signed [63:0]             new_vel_z,
  output logic signed [63:0]             fatigue_out,
  output logic                           inside_zone,
  output logic                           plastic_flow
);

  localparam int QL     = ivd_pkg::QMUL_LAT;
  localparam int SQ_LAT = ivd_pkg::SQRT_STEPS / SQRT_STEPS_PER_STAGE;
  localparam int DV_LAT = 1 + ivd_pkg::DIV_STEPS / DIV_STEPS_PER_STAGE;
  // inside flag from the distance compare to the output stage
  localparam int IN_DEPTH = SQ_LAT + DV_LAT + 3 * QL + 1;
  // vertex from accept to the output stage
  localparam int VTX_DEPTH = 1 + QL + 1 + IN_DEPTH;
  localparam int VTX_W = $bits(ivd_pkg::vtx_t);

  // config registers
  logic signed [63:0] centre_x, centre_y, centre_z;
  logic signed [63:0] impact_force, yield_strength;
  logic [62:0]        impact_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x       <= '0;
      centre_y       <= '0;
      centre_z       <= '0;
      impact_force   <= '0;
      impact_radius  <= ivd_pkg::RADIUS_RESET;
      yield_strength <= ivd_pkg::YIELD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ivd_pkg::CFG_CENTRE_X:       centre_x       <= cfg_data;
        ivd_pkg::CFG_CENTRE_Y:       centre_y       <= cfg_data;
        ivd_pkg::CFG_CENTRE_Z:       centre_z       <= cfg_data;
        ivd_pkg::CFG_IMPACT_FORCE:   impact_force   <= cfg_data;
        ivd_pkg::CFG_IMPACT_RADIUS:  impact_radius  <= cfg_data[62:0];
        ivd_pkg::CFG_YIELD_STRENGTH: yield_strength <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline advances together; a held result stalls every stage
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // vertex side path with the valid bits
  ivd_pkg::vtx_t vtx_in, vtx_out;
  logic [VTX_W-1:0] vtx_bits;
  logic             vtx_valid;

  assign vtx_in = '{pos_x: pos_x, pos_y: pos_y, pos_z: pos_z, vel_x: vel_x,
                    vel_y: vel_y, vel_z: vel_z, fatigue: fatigue_in};

  ivd_delay #(.WIDTH(VTX_W), .DEPTH(VTX_DEPTH)) u_vtx_dly (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_valid), .in_data(vtx_in),
    .out_valid(vtx_valid), .out_data(vtx_bits)
  );
  assign vtx_out = ivd_pkg::vtx_t'(vtx_bits);

  // offsets from the centre
  logic signed [63:0] dx, dy, dz;

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= ivd_pkg::sat_sub(pos_x, centre_x);
      dy <= ivd_pkg::sat_sub(pos_y, centre_y);
      dz <= ivd_pkg::sat_sub(pos_z, centre_z);
    end
  end

  // squares and radius squared
  logic signed [63:0] sq_x, sq_y, sq_z, r2_q;

  ivd_qmul u_sq_x (.clk(clk), .en(en), .a(dx), .b(dx), .prod(sq_x));
  ivd_qmul u_sq_y (.clk(clk), .en(en), .a(dy), .b(dy), .prod(sq_y));
  ivd_qmul u_sq_z (.clk(clk), .en(en), .a(dz), .b(dz), .prod(sq_z));
  ivd_qmul u_r2 (.clk(clk), .en(en), .a({1'b0, impact_radius}),
                 .b({1'b0, impact_radius}), .prod(r2_q));

  logic signed [63:0] dsq, r2;

  always_ff @(posedge clk) begin
    if (en) begin
      dsq <= ivd_pkg::sat_add(ivd_pkg::sat_add(sq_x, sq_y), sq_z);
      r2  <= r2_q;
    end
  end

  // inside flag rides along to the output stage
  logic inside_cmp, inside_d;
  assign inside_cmp = dsq < r2;

  ivd_delay #(.WIDTH(1), .DEPTH(IN_DEPTH)) u_in_dly (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(1'b0), .in_data(inside_cmp),
    .out_valid(), .out_data(inside_d)
  );

  // distance, floor square root
  logic [47:0] root_q;

  ivd_sqrt #(.STEPS_PER_STAGE(SQRT_STEPS_PER_STAGE)) u_sqrt (
    .clk(clk), .en(en), .value(dsq), .root(root_q)
  );

  // falloff = (radius - distance) / radius
  logic [62:0] fall_num;
  logic [63:0] fall;
  assign fall_num = impact_radius - {15'b0, root_q};

  ivd_div #(.STEPS_PER_STAGE(DIV_STEPS_PER_STAGE)) u_div (
    .clk(clk), .en(en), .num(fall_num), .den(impact_radius), .quo(fall)
  );

  // force = impact_force * falloff^2
  logic signed [63:0] fall_sq, force_q;

  ivd_qmul u_fall_sq (.clk(clk), .en(en), .a(fall), .b(fall), .prod(fall_sq));
  ivd_qmul u_force (.clk(clk), .en(en), .a(impact_force), .b(fall_sq),
                    .prod(force_q));

  logic signed [63:0] force_r, excess;
  logic               plastic_r, plastic_d;

  always_ff @(posedge clk) begin
    if (en) begin
      force_r   <= force_q;
      excess    <= ivd_pkg::sat_sub(force_q, yield_strength);
      plastic_r <= force_q > yield_strength;
    end
  end

  // fatigue gain, plastic drop, elastic velocity drop in parallel
  logic signed [63:0] fat_inc, disp, vel_drop;

  ivd_qmul u_fat (.clk(clk), .en(en), .a(force_r), .b(ivd_pkg::K_FATIGUE_SCALE),
                  .prod(fat_inc));
  ivd_qmul u_disp (.clk(clk), .en(en), .a(excess), .b(ivd_pkg::K_HALF),
                   .prod(disp));
  ivd_qmul u_vdrop (.clk(clk), .en(en), .a(force_r), .b(ivd_pkg::K_TENTH),
                    .prod(vel_drop));

  ivd_delay #(.WIDTH(1), .DEPTH(QL)) u_pl_dly (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(1'b0), .in_data(plastic_r),
    .out_valid(), .out_data(plastic_d)
  );

  // output stage
  ivd_pkg::vtx_t res;
  logic          plastic_res;

  always_comb begin
    res         = vtx_out;
    plastic_res = 1'b0;
    if (inside_d) begin
      res.fatigue = ivd_pkg::sat_add(vtx_out.fatigue, fat_inc);
      if (plastic_d) begin
        plastic_res = 1'b1;
        res.pos_y   = ivd_pkg::sat_sub(vtx_out.pos_y, disp);
        res.vel_x   = '0;
        res.vel_y   = '0;
        res.vel_z   = '0;
      end else begin
        res.vel_y = ivd_pkg::sat_sub(vtx_out.vel_y, vel_drop);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vtx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      new_pos_x    <= res.pos_x;
      new_pos_y    <= res.pos_y;
      new_pos_z    <= res.pos_z;
      new_vel_x    <= res.vel_x;
      new_vel_y    <= res.vel_y;
      new_vel_z    <= res.vel_z;
      fatigue_out  <= res.fatigue;
      inside_zone  <= inside_d;
      plastic_flow <= plastic_res;
    end
  end

  // plastic flow only happens inside the zone
  a_plastic_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid && plastic_flow |-> inside_zone)
    else $error("plastic flow outside zone");

  // plastic flow clears the velocity
  a_plastic_vel: assert property (@(posedge clk) disable iff (rst)
    out_valid && plastic_flow |-> new_vel_x == '0 && new_vel_y == '0 && new_vel_z == '0)
    else $error("velocity not cleared after plastic flow");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

FILE: rtl/core/ivd_qmul.sv
module ivd_qmul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] prod
);

  logic        neg1, neg2;
  logic [63:0] ma, mb;
  logic [63:0] p00, p01, p10, p11;
  logic [34:0] mid;
  logic [63:0] hi;
  logic [63:0] m;
  logic signed [63:0] res;

  // magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= a[63] ^ b[63];
      ma   <= a[63] ? 64'(-a) : a;
      mb   <= b[63] ? 64'(-b) : b;
    end
  end

  // 32x32 partial products
  always_ff @(posedge clk) begin
    if (en) begin
      neg2 <= neg1;
      p00  <= ma[31:0] * mb[31:0];
      p01  <= ma[31:0] * mb[63:32];
      p10  <= ma[63:32] * mb[31:0];
      p11  <= ma[63:32] * mb[63:32];
    end
  end

  // combine, truncate to q32.32, saturate
  always_comb begin
    mid = {3'b0, p00[63:32]} + {3'b0, p01[31:0]} + {3'b0, p10[31:0]};
    hi  = p11 + {32'b0, p01[63:32]} + {32'b0, p10[63:32]} + {61'b0, mid[34:32]};
    m   = {hi[31:0], mid[31:0]};
    if (|hi[63:32]) begin
      res = neg2 ? ivd_pkg::S64_MIN : ivd_pkg::S64_MAX;
    end else if (neg2) begin
      res = m[63] ? ivd_pkg::S64_MIN : $signed(64'(-m));
    end else begin
      res = m[63] ? ivd_pkg::S64_MAX : $signed(m);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= res;
    end
  end

endmodule

FILE: rtl/core/ivd_sqrt.sv
module ivd_sqrt #(
  parameter int STEPS_PER_STAGE = ivd_pkg::SQRT_STEPS_PER_STAGE
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] value,
  output logic [47:0] root
);

  localparam int STAGES = ivd_pkg::SQRT_STEPS / STEPS_PER_STAGE;

  typedef struct packed {
    logic [51:0] rem;
    logic [47:0] root;
    logic [95:0] rad;
  } sq_t;

  // two radicand bits per step, restoring digit recurrence
  function automatic sq_t sq_steps(input sq_t s);
    sq_t r;
    logic [51:0] cur;
    logic [51:0] trial;
    r = s;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      cur   = {r.rem[49:0], r.rad[95:94]};
      trial = {2'b00, r.root, 2'b01};
      if (cur >= trial) begin
        r.rem  = cur - trial;
        r.root = {r.root[46:0], 1'b1};
      end else begin
        r.rem  = cur;
        r.root = {r.root[46:0], 1'b0};
      end
      r.rad = {r.rad[93:0], 2'b00};
    end
    return r;
  endfunction

  sq_t init;
  sq_t pipe [STAGES];

  assign init = '{rem: '0, root: '0, rad: {value, 32'b0}};

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= sq_steps(init);
    end
  end

  for (genvar s = 1; s < STAGES; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        pipe[s] <= sq_steps(pipe[s-1]);
      end
    end
  end

  assign root = pipe[STAGES-1].root;

endmodule

FILE: rtl/core/ivd_div.sv
module ivd_div #(
  parameter int STEPS_PER_STAGE = ivd_pkg::DIV_STEPS_PER_STAGE
) (
  input  logic        clk,
  input  logic        en,
  input  logic [62:0] num,
  input  logic [62:0] den,
  output logic [63:0] quo
);

  localparam int STAGES = ivd_pkg::DIV_STEPS / STEPS_PER_STAGE;

  typedef struct packed {
    logic [62:0] rem;
    logic [32:0] quo;
  } dv_t;

  // restoring division, one fraction bit per step
  function automatic dv_t dv_steps(input dv_t s, input logic [62:0] d);
    dv_t r;
    logic [63:0] cur;
    r = s;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      cur = {r.rem, 1'b0};
      if (cur >= {1'b0, d}) begin
        r.rem = 63'(cur - {1'b0, d});
        r.quo = {r.quo[31:0], 1'b1};
      end else begin
        r.rem = cur[62:0];
        r.quo = {r.quo[31:0], 1'b0};
      end
    end
    return r;
  endfunction

  dv_t head;
  dv_t pipe [STAGES];

  // integer part, zero or one
  always_ff @(posedge clk) begin
    if (en) begin
      if (num >= den) begin
        head <= '{rem: num - den, quo: 33'd1};
      end else begin
        head <= '{rem: num, quo: 33'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= dv_steps(head, den);
    end
  end

  for (genvar s = 1; s < STAGES; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        pipe[s] <= dv_steps(pipe[s-1], den);
      end
    end
  end

  assign quo = {31'b0, pipe[STAGES-1].quo};

endmodule

FILE: rtl/core/ivd_delay.sv
module ivd_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_data
);

  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] tap [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < DEPTH; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= in_data;
      for (int i = 1; i < DEPTH; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign out_data  = tap[DEPTH-1];

endmodule

FILE: bench/tb_top.sv
module tb_top;

  typedef logic signed [63:0] q_t;

  // one vertex going in, one deformed vertex coming out
  typedef struct {
    q_t px, py, pz, vx, vy, vz, fat;
  } vertex_t;

  typedef struct packed {
    q_t px, py, pz, vx, vy, vz, fat;
    logic in_zone, plastic;
  } deformed_t;

  // impact settings as the predictor sees them
  q_t ctr_x, ctr_y, ctr_z, force_cfg, yield_cfg;
  logic [62:0] radius_cfg;

  function automatic q_t fx_add(q_t a, q_t b);
    logic signed [64:0] s;
    s = a + b;
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return ivd_pkg::S64_MAX;
    if (s < -65'sh0_8000_0000_0000_0000) return ivd_pkg::S64_MIN;
    return s[63:0];
  endfunction

  function automatic q_t fx_sub(q_t a, q_t b);
    logic signed [64:0] s;
    s = a - b;
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return ivd_pkg::S64_MAX;
    if (s < -65'sh0_8000_0000_0000_0000) return ivd_pkg::S64_MIN;
    return s[63:0];
  endfunction

  // exact product, truncated toward zero, saturated
  function automatic q_t fx_mul(q_t a, q_t b);
    logic [63:0] ma, mb;
    logic [127:0] p;
    logic [95:0] m;
    logic neg;
    neg = a[63] ^ b[63];
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    p = ma * mb;
    m = p[127:32];
    if (neg) begin
      if (m >= 96'h8000_0000_0000_0000) return ivd_pkg::S64_MIN;
      return -$signed(m[63:0]);
    end
    if (m > 96'h7FFF_FFFF_FFFF_FFFF) return ivd_pkg::S64_MAX;
    return m[63:0];
  endfunction

  function automatic q_t fx_sqrt(q_t v);
    logic [127:0] t, c2;
    logic [63:0] r, c;
    t = {64'd0, v} << 32;
    r = 0;
    for (int b = 47; b >= 0; b--) begin
      c = r | (64'd1 << b);
      c2 = c * c;
      if (c2 <= t) r = c;
    end
    return r;
  endfunction

  function automatic q_t fx_frac(logic [63:0] n, logic [63:0] d);
    logic [127:0] q;
    q = ({64'd0, n} << 32) / d;
    return q[63:0];
  endfunction

  function automatic deformed_t deform(vertex_t v);
    deformed_t o;
    q_t dx, dy, dz, dsq, r2, rt, fall, frc, disp;
    o = '{v.px, v.py, v.pz, v.vx, v.vy, v.vz, v.fat, 1'b0, 1'b0};
    dx = fx_sub(v.px, ctr_x);
    dy = fx_sub(v.py, ctr_y);
    dz = fx_sub(v.pz, ctr_z);
    dsq = fx_add(fx_add(fx_mul(dx, dx), fx_mul(dy, dy)), fx_mul(dz, dz));
    r2 = fx_mul({1'b0, radius_cfg}, {1'b0, radius_cfg});
    if (dsq < r2) begin
      rt = fx_sqrt(dsq);
      fall = fx_frac({1'b0, radius_cfg} - rt, {1'b0, radius_cfg});
      frc = fx_mul(force_cfg, fx_mul(fall, fall));
      o.in_zone = 1;
      o.fat = fx_add(v.fat, fx_mul(frc, ivd_pkg::K_FATIGUE_SCALE));
      if (frc > yield_cfg) begin
        disp = fx_mul(fx_sub(frc, yield_cfg), ivd_pkg::K_HALF);
        o.plastic = 1;
        o.py = fx_sub(v.py, disp);
        o.vx = 0;
        o.vy = 0;
        o.vz = 0;
      end else begin
        o.vy = fx_sub(v.vy, fx_mul(frc, ivd_pkg::K_TENTH));
      end
    end
    return o;
  endfunction

  // queue of predicted vertices, checked in order
  class deform_scoreboard;
    deformed_t pending[$];
    int mismatches = 0;

    function void note_vertex(vertex_t v);
      pending.push_back(deform(v));
    endfunction

    function void check_vertex(deformed_t a);
      deformed_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", a);
        return;
      end
      e = pending.pop_front();
      if (a !== e) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", e, a);
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_write;
  logic [ivd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  q_t pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, fatigue_in;
  q_t new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z, fatigue_out;
  logic inside_zone, plastic_flow;

  impact_vertex_deformation_top dut (.*);

  deform_scoreboard sb = new();
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 0;
  longint cycles = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // generous limit: ~600 items with long stalls and the pipeline depth
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_vertex('{new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                        new_vel_z, fatigue_out, inside_zone, plastic_flow});
    out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(logic [ivd_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      ivd_pkg::CFG_CENTRE_X: ctr_x = val;
      ivd_pkg::CFG_CENTRE_Y: ctr_y = val;
      ivd_pkg::CFG_CENTRE_Z: ctr_z = val;
      ivd_pkg::CFG_IMPACT_FORCE: force_cfg = val;
      ivd_pkg::CFG_IMPACT_RADIUS: radius_cfg = val[62:0];
      ivd_pkg::CFG_YIELD_STRENGTH: yield_cfg = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 0;
    @(posedge clk);
  endtask

  // offer one vertex and wait for its acceptance
  task automatic send_vertex(vertex_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    pos_x <= v.px; pos_y <= v.py; pos_z <= v.pz;
    vel_x <= v.vx; vel_y <= v.vy; vel_z <= v.vz;
    fatigue_in <= v.fat;
    do @(posedge clk); while (!in_ready);
    sb.note_vertex(v);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  function automatic q_t rnd64();
    return {$urandom, $urandom};
  endfunction

  // small offset around the centre in Q32.32, a random value shifted right by 28 to 63 bits
  function automatic q_t near(q_t c);
    q_t off;
    off = $signed({$urandom, $urandom}) >>> $urandom_range(63, 28);
    return fx_add(c, off);
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t v;
    v = '{rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64()};
    if ($urandom_range(9) < 8) begin
      // mostly vertices near the impact so the zone math is exercised
      v.px = near(ctr_x);
      v.py = near(ctr_y);
      v.pz = near(ctr_z);
      if ($urandom_range(3) == 0) v.fat = ivd_pkg::S64_MAX - $urandom_range(1000);
    end
    return v;
  endfunction

  function automatic q_t rand_setting();
    case ($urandom_range(5))
      0: return ivd_pkg::S64_MAX;
      1: return ivd_pkg::S64_MIN;
      2: return 0;
      default: return $signed({$urandom, $urandom}) >>> $urandom_range(40, 20);
    endcase
  endfunction

  task automatic random_config(int phase);
    write_reg(ivd_pkg::CFG_CENTRE_X, rand_setting() >>> 8);
    write_reg(ivd_pkg::CFG_CENTRE_Y, rand_setting() >>> 8);
    write_reg(ivd_pkg::CFG_CENTRE_Z, rand_setting() >>> 8);
    write_reg(ivd_pkg::CFG_IMPACT_FORCE, rand_setting());
    write_reg(ivd_pkg::CFG_YIELD_STRENGTH, rand_setting());
    case (phase % 4)
      0: write_reg(ivd_pkg::CFG_IMPACT_RADIUS, 64'd1);
      1: write_reg(ivd_pkg::CFG_IMPACT_RADIUS, 64'h7FFF_FFFF_FFFF_FFFF);
      default: write_reg(ivd_pkg::CFG_IMPACT_RADIUS,
                         {$urandom_range(1000, 1), 32'd0} | $urandom);
    endcase
  endtask

  initial begin
    rst = 1;
    cfg_write = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; out_ready = 0;
    pos_x = 0; pos_y = 0; pos_z = 0; vel_x = 0; vel_y = 0; vel_z = 0;
    fatigue_in = 0;
    ctr_x = 0; ctr_y = 0; ctr_z = 0; force_cfg = 0;
    radius_cfg = ivd_pkg::RADIUS_RESET; yield_cfg = ivd_pkg::YIELD_RESET;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset settings, then strong force on vertices outside the zone, then elastic hits
    send_vertex('{0, 0, 0, 5, 7, 9, 11});
    send_vertex('{ivd_pkg::S64_MAX, ivd_pkg::S64_MIN, ivd_pkg::S64_MAX, ivd_pkg::S64_MIN,
                  ivd_pkg::S64_MAX, ivd_pkg::S64_MIN, ivd_pkg::S64_MAX});
    send_vertex('{ivd_pkg::S64_MIN, ivd_pkg::S64_MAX, ivd_pkg::S64_MIN, ivd_pkg::S64_MAX,
                  ivd_pkg::S64_MIN, ivd_pkg::S64_MAX, ivd_pkg::S64_MIN});
    drain();
    write_reg(ivd_pkg::CFG_IMPACT_FORCE, 64'sd1000 <<< 32);
    write_reg(ivd_pkg::CFG_YIELD_STRENGTH, 64'sd10 <<< 32);
    for (int k = 0; k < 6; k++)
      send_vertex('{q_t'(k) <<< 31, ivd_pkg::S64_MIN + k, 0, 64'sd3 <<< 32,
                    ivd_pkg::S64_MIN, -64'sd1, ivd_pkg::S64_MAX - k});
    send_vertex('{64'sd5 <<< 32, 0, 0, 1, 2, 3, 4});   // exactly on the rim
    drain();
    write_reg(ivd_pkg::CFG_YIELD_STRENGTH, ivd_pkg::S64_MAX);   // elastic only
    write_reg(ivd_pkg::CFG_IMPACT_FORCE, ivd_pkg::S64_MIN);
    for (int k = 0; k < 4; k++)
      send_vertex('{0, q_t'(k) <<< 30, 0, 0, ivd_pkg::S64_MAX - k, 0,
                    ivd_pkg::S64_MIN + k});
    drain();
    write_reg(ivd_pkg::CFG_IMPACT_RADIUS, 64'd1);      // radius squared is zero
    send_vertex('{0, 0, 0, 1, 1, 1, 1});
    drain();

    // random phases with the idling mixes
    for (int ph = 0; ph < 12; ph++) begin
      random_config(ph);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      if (ph == 4) begin
        // long receiver hold-off while the sender keeps pushing
        fork
          begin
            hold_off = 1;
            repeat (300) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      repeat (45) send_vertex(rand_vertex());
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/ivd_pkg.sv
rtl/core/ivd_qmul.sv
rtl/core/ivd_sqrt.sv
rtl/core/ivd_div.sv
rtl/core/ivd_delay.sv
rtl/core/impact_vertex_deformation_top.sv
bench/tb_top.sv
